// ----- design/u8dec_pkg.sv -----
// ---------------------------------------------------------------------------
// u8dec_pkg: shared types and constants for the UTF-8 stream decoder
// Status codes, register indexes, decoder state and result beat structures.
// ---------------------------------------------------------------------------
package u8dec_pkg;

    localparam int          COUNT_BITS      = 16;
    localparam logic        ALLOW_FOUR_BYTE = 1'b1;
    localparam int          CMP_W           = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [20:0] CP_MAX          = 21'h10FFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic        CFG_MAX_CHARS   = 1'b0;
    localparam logic        CFG_LIMIT_EN    = 1'b1;

    localparam logic [15:0] MAX_CHARS_RST   = 16'hFFFF;
    localparam logic        LIMIT_EN_RST    = 1'b1;

    typedef enum logic [1:0] {
        ST_CHAR  = 2'd0,
        ST_TERM  = 2'd1,
        ST_BAD   = 2'd2,
        ST_LIMIT = 2'd3
    } t_status;

    typedef struct packed {
        logic                  stopped;
        logic [1:0]            remaining;
        logic [20:0]           partial;
        logic [COUNT_BITS-1:0] count;
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [20:0] code_point;
        t_status     status;
        logic [15:0] char_count;
    } t_result;

endpackage

// ----- design/u8dec_step.sv -----
// ---------------------------------------------------------------------------
// u8dec_step: per-byte decode step
// Takes the current decoder state and one byte, gives the next state and
// at most one result beat.
// ---------------------------------------------------------------------------
module u8dec_step (
    input  u8dec_pkg::t_state  i_state,
    input  logic [7:0]         i_data_byte,
    input  logic               i_string_start,
    input  logic [15:0]        i_max_chars,
    input  logic               i_limit_enable,
    output u8dec_pkg::t_state  o_state,
    output u8dec_pkg::t_result o_result
);
    import u8dec_pkg::*;

    t_state            s;
    t_state            n;
    logic [20:0]       fin_val;
    logic              fin_go;
    logic              limit_hit;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  max_ext;

    always_comb begin
        s = i_state;
        if (i_string_start) begin
            s = '0;
        end
        cnt_ext   = CMP_W'(s.count);
        max_ext   = CMP_W'(i_max_chars);
        limit_hit = i_limit_enable && (cnt_ext >= max_ext);

        n        = s;
        o_result = '0;
        fin_go   = 1'b0;
        fin_val  = '0;

        if (s.stopped) begin
            n = s;
        end else if (s.remaining != 2'd0) begin
            if (i_data_byte[7:6] != 2'b10) begin
                n.remaining       = 2'd0;
                n.partial         = '0;
                n.stopped         = 1'b1;
                o_result.valid    = 1'b1;
                o_result.status   = ST_BAD;
            end else if (s.remaining == 2'd1) begin
                fin_go  = 1'b1;
                fin_val = {s.partial[14:0], i_data_byte[5:0]};
            end else begin
                n.partial   = {s.partial[14:0], i_data_byte[5:0]};
                n.remaining = s.remaining - 2'd1;
            end
        end else if (limit_hit) begin
            n.stopped       = 1'b1;
            o_result.valid  = 1'b1;
            o_result.status = ST_LIMIT;
        end else if (i_data_byte[7] == 1'b0) begin
            fin_go  = 1'b1;
            fin_val = {14'd0, i_data_byte[6:0]};
        end else if (i_data_byte[7:5] == 3'b110) begin
            n.partial   = {16'd0, i_data_byte[4:0]};
            n.remaining = 2'd1;
        end else if (i_data_byte[7:4] == 4'b1110) begin
            n.partial   = {17'd0, i_data_byte[3:0]};
            n.remaining = 2'd2;
        end else if (ALLOW_FOUR_BYTE && (i_data_byte[7:3] == 5'b11110)) begin
            n.partial   = {18'd0, i_data_byte[2:0]};
            n.remaining = 2'd3;
        end else begin
            n.remaining     = 2'd0;
            n.partial       = '0;
            n.stopped       = 1'b1;
            o_result.valid  = 1'b1;
            o_result.status = ST_BAD;
        end

        if (fin_go) begin
            n.remaining    = 2'd0;
            n.partial      = '0;
            o_result.valid = 1'b1;
            if (fin_val == 21'd0) begin
                n.stopped       = 1'b1;
                o_result.status = ST_TERM;
            end else if (fin_val > CP_MAX) begin
                n.stopped       = 1'b1;
                o_result.status = ST_BAD;
            end else begin
                if (s.count != COUNT_MAX) begin
                    n.count = s.count + COUNT_BITS'(1);
                end
                o_result.status     = ST_CHAR;
                o_result.code_point = fin_val;
            end
        end

        o_result.char_count = cnt_ext[15:0];
        if (fin_go) begin
            o_result.char_count = 16'(CMP_W'(n.count));
        end
        o_state = n;
    end

endmodule

// ----- design/utf8_stream_decoder.sv -----
// ---------------------------------------------------------------------------
// utf8_stream_decoder: byte-serial UTF-8 decoder with a character limit
// Takes one byte per beat and gives a result beat for each finished
// character, terminator, malformed sequence or limit stop.
// ---------------------------------------------------------------------------
// One byte is accepted in every cycle in which the input is not stalled: the
// decode of a byte is a single combinational step from the state registers,
// and its result is registered. Results go through a two-entry output buffer,
// so input stalls only when both entries hold results that the sink has not
// taken. A new string begins with a beat that has string_start set; after
// reset decoding is already armed. Configuration writes take effect from the
// next byte.
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_string_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic [1:0]  o_status,
    output logic [15:0] o_char_count,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wr_data
);
    import u8dec_pkg::*;

    logic [15:0] r_max_chars;
    logic        r_limit_en;
    t_state      r_state;
    t_state      n_state;
    t_result     step_res;
    t_result     r_out;
    t_result     r_skid;
    logic        accept;
    logic        out_free;

    u8dec_step u_step (
        .i_state        (r_state),
        .i_data_byte    (i_data_byte),
        .i_string_start (i_string_start),
        .i_max_chars    (r_max_chars),
        .i_limit_enable (r_limit_en),
        .o_state        (n_state),
        .o_result       (step_res)
    );

    assign o_stall  = r_skid.valid;
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out.valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= MAX_CHARS_RST;
            r_limit_en  <= LIMIT_EN_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAX_CHARS: r_max_chars <= i_cfg_wr_data;
                CFG_LIMIT_EN:  r_limit_en  <= i_cfg_wr_data[0];
                default:       r_limit_en  <= r_limit_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // two-entry result buffer: r_out faces the sink, r_skid catches overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid.valid) begin
                    r_out        <= r_skid;
                    r_skid.valid <= 1'b0;
                end else begin
                    r_out <= {accept && step_res.valid, step_res.code_point,
                              step_res.status, step_res.char_count};
                end
            end else if (accept && step_res.valid) begin
                r_skid <= step_res;
            end
        end
    end

    assign o_valid      = r_out.valid;
    assign o_code_point = r_out.code_point;
    assign o_status     = r_out.status;
    assign o_char_count = r_out.char_count;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> r_out.valid)
        else $error("skid entry held while output register empty");

    a_nonchar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_CHAR)) |-> (o_code_point == 21'd0))
        else $error("non-character status with non-zero code point");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_CHAR)) |->
            ((o_code_point != 21'd0) && (o_code_point <= CP_MAX)))
        else $error("character result out of range");

    a_stop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stopped |-> (r_state.remaining == 2'd0))
        else $error("stopped with a partial character pending");

endmodule
